// ----- rtl/bbe_pkg.sv -----
`default_nettype none
package bbe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int LINE_ROWS  = 3;
    localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef logic [23:0] t_pixel;

endpackage
`default_nettype wire

// ----- rtl/bbe_pix_if.sv -----
`default_nettype none
interface bbe_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/bbe_res_if.sv -----
`default_nettype none
interface bbe_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [11:0] out_row;
    logic [9:0]  out_column;
    logic        run_last;
    logic        frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_row, output out_column, output run_last,
                    output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_column, input run_last,
                  input frame_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/bbe_line_mem.sv -----
`default_nettype none
module bbe_line_mem
    import bbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_pixel            i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_pixel                 o_rdata
);

    t_pixel r_mem [0:LINE_DEPTH-1];
    t_pixel r_rdata;

    // Three pixel rows; read data is registered and comes in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/bbe_div.sv -----
`default_nettype none
module bbe_div
    import bbe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [2:0][SUM_W-1:0] i_num,
    input  wire logic [CNT_W-1:0]      i_den,
    output logic                       o_done,
    output logic [2:0][7:0]            o_quot
);

    logic [2:0][SUM_W-1:0] r_q;
    logic [2:0][CNT_W-1:0] r_rem;
    logic [CNT_W-1:0]      r_den;
    logic [CNT_W-1:0]      r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [2:0][SUM_W-1:0] n_q;
    logic [2:0][CNT_W-1:0] n_rem;

    // One restoring step per cycle on all three channels.
    always_comb begin
        logic [CNT_W:0] t;
        for (int k = 0; k < 3; k++) begin
            t = {r_rem[k], r_q[k][SUM_W-1]};
            if (t >= {1'b0, r_den}) begin
                n_rem[k] = CNT_W'(t - {1'b0, r_den});
                n_q[k]   = {r_q[k][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = t[CNT_W-1:0];
                n_q[k]   = {r_q[k][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_quot[k] = r_q[k][7:0];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/box_blur_3x3_edge_average_unit.sv -----
// Channel   Direction  Handshake      Word
// i_pix     in         valid/ready    in_red, in_green, in_blue
// o_res     out        valid/ready    blurred RGB, row, column, run_last, frame_end
// i_cfg_*   in         write enable   register index and data
// A pixel is written to the line memory in the cycle it is accepted.
// Each result passes through picking it, 9 line-memory reads through the
// single read port, a drain state, the divider state (start, 12 restoring
// steps, done) and the output load.
// A pixel yields 0 to 4 results.
// Reset is synchronous; the line memory needs no clearing. A stalled output
// holds the output register, and the next result waits for it to empty; once
// the last result is loaded, the next pixel is taken meanwhile.
`default_nettype none
module box_blur_3x3_edge_average_unit
    import bbe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bbe_pix_if.sink                    i_pix,
    bbe_res_if.source                  o_res
);

    typedef enum logic [2:0] {S_IDLE, S_CAND, S_READ, S_DRAIN, S_DIV, S_OUT} t_state;

    t_state r_state;
    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [COL_W-1:0]   r_col, r_cur_c, r_ocol;
    logic [ROW_W-1:0]   r_row, r_cur_r, r_orow;
    logic [1:0]         r_slot, r_cur_slot;
    logic [3:0]         r_mask;
    logic               r_fend, r_last, r_dr;
    logic [1:0]         r_nr, r_nc;
    logic               r_pend, r_ok;
    logic [2:0][SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_div_start;
    logic               r_out_valid;
    logic [2:0][7:0]    r_out_rgb;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic               r_out_last, r_out_fend;

    logic [CFG_W_W-1:0] eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic               in_acc, out_acc;
    logic               c_last, r_lastrow;
    t_pixel             rdata;
    logic               rd_en, rd_ok;
    logic [ADDR_W-1:0]  rd_addr;
    logic [1:0]         rd_slot;
    logic [COL_W-1:0]   rd_col;
    logic [2:0][SUM_W-1:0] div_num;
    logic               div_done;
    logic [2:0][7:0]    div_quot;

    // Effective frame size: zero acts as one, large values saturate.
    always_comb begin
        if (r_cfg_w == '0)                       eff_w = CFG_W_W'(1);
        else if (r_cfg_w > CFG_W_W'(MAX_WIDTH))  eff_w = CFG_W_W'(MAX_WIDTH);
        else                                     eff_w = r_cfg_w;
        if (r_cfg_h == '0)                       eff_h = CFG_H_W'(1);
        else if (r_cfg_h > CFG_H_W'(MAX_HEIGHT)) eff_h = CFG_H_W'(MAX_HEIGHT);
        else                                     eff_h = r_cfg_h;
    end

    assign in_acc    = i_pix.valid && (r_state == S_IDLE);
    assign out_acc   = r_out_valid && o_res.ready;
    assign c_last    = ({1'b0, r_col} == CFG_W_W'(eff_w - 1'b1));
    assign r_lastrow = ({1'b0, r_row} == CFG_H_W'(eff_h - 1'b1));

    // Neighbor address for the current window tap and whether it lies in the frame.
    always_comb begin
        logic [1:0] d;
        rd_ok = 1'b1;
        if (r_nr == 2'd0 && r_orow == '0) rd_ok = 1'b0;
        if (r_nr == 2'd2 && ({1'b0, r_orow} + 1'b1) >= eff_h) rd_ok = 1'b0;
        if (r_nc == 2'd0 && r_ocol == '0) rd_ok = 1'b0;
        if (r_nc == 2'd2 && ({1'b0, r_ocol} + 1'b1) >= eff_w) rd_ok = 1'b0;
        rd_col = COL_W'({1'b0, r_ocol} + {{(COL_W-1){1'b0}}, r_nc} - 1'b1);
        // Rows back from the current row: result row offset plus tap offset.
        d = 2'({1'b0, r_dr} + 2'd1 - r_nr);
        case ({r_cur_slot, d})
            4'b00_00: rd_slot = 2'd0;
            4'b00_01: rd_slot = 2'd2;
            4'b00_10: rd_slot = 2'd1;
            4'b01_00: rd_slot = 2'd1;
            4'b01_01: rd_slot = 2'd0;
            4'b01_10: rd_slot = 2'd2;
            4'b10_00: rd_slot = 2'd2;
            4'b10_01: rd_slot = 2'd1;
            4'b10_10: rd_slot = 2'd0;
            default:  rd_slot = 2'd0;
        endcase
        rd_addr = ADDR_W'({rd_slot, rd_col});
        rd_en   = (r_state == S_READ);
    end

    bbe_line_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (ADDR_W'({r_slot, r_col})),
        .i_wdata ({i_pix.in_red, i_pix.in_green, i_pix.in_blue}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // Round half up by adding half the count before dividing.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            div_num[k] = r_sum[k] + SUM_W'(r_cnt >> 1);
        end
    end

    bbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer: configuration writes, position counters, result selection, window reads and output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= CFG_W_W'(640);
            r_cfg_h     <= CFG_H_W'(480);
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= '0;
            r_mask      <= '0;
            r_pend      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we && (i_cfg_index == CFG_IMAGE_WIDTH ||
                             i_cfg_index == CFG_IMAGE_HEIGHT)) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                end else begin
                    r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                end
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= '0;
            end

            // Accumulate the tap read in the previous cycle.
            if (r_pend && r_ok) begin
                r_sum[0] <= r_sum[0] + SUM_W'(rdata[23:16]);
                r_sum[1] <= r_sum[1] + SUM_W'(rdata[15:8]);
                r_sum[2] <= r_sum[2] + SUM_W'(rdata[7:0]);
                r_cnt    <= r_cnt + 1'b1;
            end
            r_pend <= rd_en;
            r_ok   <= rd_ok;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cur_c    <= r_col;
                        r_cur_r    <= r_row;
                        r_cur_slot <= r_slot;
                        r_mask <= {r_lastrow & c_last, r_lastrow & (r_col != '0),
                                   (r_row != '0) & c_last,
                                   (r_row != '0) & (r_col != '0)};
                        r_fend <= r_lastrow & c_last;
                        if (c_last) begin
                            r_col <= '0;
                            if (r_lastrow) begin
                                r_row  <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row  <= r_row + 1'b1;
                                r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_nr  <= '0;
                    r_nc  <= '0;
                    r_sum <= '0;
                    r_cnt <= '0;
                    r_state <= S_READ;
                    if (r_mask[0]) begin
                        r_dr <= 1'b1; r_orow <= r_cur_r - 1'b1; r_ocol <= r_cur_c - 1'b1;
                        r_mask[0] <= 1'b0; r_last <= (r_mask[3:1] == '0);
                    end else if (r_mask[1]) begin
                        r_dr <= 1'b1; r_orow <= r_cur_r - 1'b1; r_ocol <= r_cur_c;
                        r_mask[1] <= 1'b0; r_last <= (r_mask[3:2] == '0);
                    end else if (r_mask[2]) begin
                        r_dr <= 1'b0; r_orow <= r_cur_r; r_ocol <= r_cur_c - 1'b1;
                        r_mask[2] <= 1'b0; r_last <= !r_mask[3];
                    end else if (r_mask[3]) begin
                        r_dr <= 1'b0; r_orow <= r_cur_r; r_ocol <= r_cur_c;
                        r_mask[3] <= 1'b0; r_last <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (r_nc == 2'd2) begin
                        r_nc <= '0;
                        if (r_nr == 2'd2) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_nr <= r_nr + 1'b1;
                        end
                    end else begin
                        r_nc <= r_nc + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || out_acc) begin
                        r_out_valid <= 1'b1;
                        r_out_rgb   <= div_quot;
                        r_out_row   <= r_orow;
                        r_out_col   <= r_ocol;
                        r_out_last  <= r_last;
                        r_out_fend  <= r_last & r_fend;
                        r_state     <= S_CAND;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pix.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.out_red    = r_out_rgb[0];
    assign o_res.out_green  = r_out_rgb[1];
    assign o_res.out_blue   = r_out_rgb[2];
    assign o_res.out_row    = r_out_row;
    assign o_res.out_column = r_out_col;
    assign o_res.run_last   = r_out_last;
    assign o_res.frame_end  = r_out_fend;

endmodule
`default_nettype wire
